// ----- rtl/core/dzte_pkg.sv -----
// ----------------------------------------------------------------------------
// dzte_pkg
// Shared types and constants for the delta zigzag trace encoder.
// ----------------------------------------------------------------------------
package dzte_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CODE_WIDTH   = 17;
    localparam int FRAME_WIDTH  = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_WIDTH-1:0] ESCAPE_CODE = CODE_WIDTH'(255);

    localparam logic STREAM_MAIN   = 1'b0;
    localparam logic STREAM_ESCAPE = 1'b1;

    typedef struct packed {
        logic                  two_results;
        logic [7:0]            first_byte;
        logic                  second_select;
        logic [CODE_WIDTH-1:0] second_code;
    } dzte_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dzte_qstat_t;

endpackage

// ----- rtl/core/dzte_front.sv -----
// ----------------------------------------------------------------------------
// dzte_front
// Accepts samples, tracks trace position and previous sample, and forms
// one queue entry per sample (raw first sample, short code or escape).
// ----------------------------------------------------------------------------
module dzte_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              frames_per_trace_we,
    input  logic [dzte_pkg::FRAME_WIDTH-1:0]  frames_per_trace,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [15:0]                       sample,
    input  dzte_pkg::dzte_qstat_t             qstat,
    output logic                              push,
    output dzte_pkg::dzte_entry_t             push_entry
);
    import dzte_pkg::*;

    logic [FRAME_WIDTH-1:0]  frames_reg;
    logic [FRAME_WIDTH-1:0]  frames_eff;
    logic [15:0]             prev_reg;
    logic [15:0]             prev_next;
    logic [FRAME_WIDTH-1:0]  index_reg;
    logic [FRAME_WIDTH-1:0]  index_next;
    logic [FRAME_WIDTH-1:0]  index_inc;
    logic [15:0]             samp;
    logic [CODE_WIDTH-1:0]   diff;
    logic [CODE_WIDTH-1:0]   zz;

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    assign samp = 16'(sample[SAMPLE_WIDTH-1:0]);
    assign diff = {1'b0, samp} - {1'b0, prev_reg};
    assign zz   = {diff[CODE_WIDTH-2:0], 1'b0} ^ {CODE_WIDTH{diff[CODE_WIDTH-1]}};

    assign frames_eff = (frames_reg == '0) ? FRAME_WIDTH'(1) : frames_reg;
    assign index_inc  = index_reg + FRAME_WIDTH'(1);

    always_comb
    begin
        if (index_reg == '0)
        begin
            push_entry.two_results   = 1'b1;
            push_entry.first_byte    = samp[7:0];
            push_entry.second_select = STREAM_MAIN;
            push_entry.second_code   = CODE_WIDTH'(samp[15:8]);
        end
        else if (zz >= ESCAPE_CODE)
        begin
            push_entry.two_results   = 1'b1;
            push_entry.first_byte    = ESCAPE_CODE[7:0];
            push_entry.second_select = STREAM_ESCAPE;
            push_entry.second_code   = zz;
        end
        else
        begin
            push_entry.two_results   = 1'b0;
            push_entry.first_byte    = zz[7:0];
            push_entry.second_select = STREAM_MAIN;
            push_entry.second_code   = zz;
        end
    end

    always_comb
    begin
        prev_next  = prev_reg;
        index_next = index_reg;
        if (push)
        begin
            prev_next  = samp;
            index_next = (index_inc >= frames_eff) ? '0 : index_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAME_WIDTH'(1);
            prev_reg   <= '0;
            index_reg  <= '0;
        end
        else
        begin
            if (frames_per_trace_we)
            begin
                frames_reg <= frames_per_trace;
            end
            prev_reg  <= prev_next;
            index_reg <= index_next;
        end
    end

endmodule

// ----- rtl/core/dzte_queue.sv -----
// ----------------------------------------------------------------------------
// dzte_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module dzte_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dzte_pkg::dzte_entry_t  push_entry,
    input  logic                   pop,
    output dzte_pkg::dzte_entry_t  head_entry,
    output dzte_pkg::dzte_qstat_t  qstat
);
    import dzte_pkg::*;

    dzte_entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]   wr_ptr_reg;
    logic [QPTR_WIDTH-1:0]   rd_ptr_reg;
    logic [QCNT_WIDTH-1:0]   count_reg;
    logic [QCNT_WIDTH-1:0]   count_next;

    assign qstat.full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_WIDTH'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_WIDTH'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full && !pop |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/dzte_back.sv -----
// ----------------------------------------------------------------------------
// dzte_back
// Splits each queue entry into its one or two results and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module dzte_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dzte_pkg::dzte_entry_t              head_entry,
    input  dzte_pkg::dzte_qstat_t              qstat,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               stream_select,
    output logic [dzte_pkg::CODE_WIDTH-1:0]    code_value,
    output logic                               last_of_run
);
    import dzte_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  phase_reg;
    logic                  phase_next;
    logic                  load;
    logic                  sel_reg;
    logic                  sel_next;
    logic [CODE_WIDTH-1:0] code_reg;
    logic [CODE_WIDTH-1:0] code_next;
    logic                  last_reg;
    logic                  last_next;

    assign load = (!valid_reg || !out_stall) && !qstat.empty;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        valid_next = valid_reg && out_stall;
        sel_next   = sel_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (!phase_reg)
            begin
                sel_next  = STREAM_MAIN;
                code_next = CODE_WIDTH'(head_entry.first_byte);
                last_next = !head_entry.two_results;
                if (head_entry.two_results)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                sel_next   = head_entry.second_select;
                code_next  = head_entry.second_code;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid     = valid_reg;
    assign stream_select = sel_reg;
    assign code_value    = code_reg;
    assign last_of_run   = last_reg;

`ifndef ASSERT_OFF
    a_escape_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && sel_reg |-> last_reg)
        else $error("escape result not last of its sample");
    a_first_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> !sel_reg && (code_reg[CODE_WIDTH-1:8] == '0))
        else $error("leading result is not a main-stream byte");
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_stall && !last_reg |=> valid_reg)
        else $error("second result missing after leading result");
`endif

endmodule

// ----- rtl/core/delta_zigzag_trace_encoder.sv -----
// ----------------------------------------------------------------------------
// delta_zigzag_trace_encoder
// Delta and zigzag encoder for sample traces: main byte stream plus
// escape value stream, one result per output handshake.
// ----------------------------------------------------------------------------
// Entries are held in the queue; results leave through the output register.
// Throughput: one result per cycle while out_stall is low, set by the single
// output register; a trace start or escape gives two results, others one.
// A four-entry queue absorbs two-result samples; in_stall is set only when full.
// Reset clears the queue, output valid, previous sample and trace position;
// the frame count resets to one.
module delta_zigzag_trace_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               frames_per_trace_we,
    input  logic [dzte_pkg::FRAME_WIDTH-1:0]   frames_per_trace,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [15:0]                        sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               stream_select,
    output logic [dzte_pkg::CODE_WIDTH-1:0]    code_value,
    output logic                               last_of_run
);
    import dzte_pkg::*;

    logic        push;
    logic        pop;
    dzte_entry_t push_entry;
    dzte_entry_t head_entry;
    dzte_qstat_t qstat;

    dzte_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .frames_per_trace_we (frames_per_trace_we),
        .frames_per_trace    (frames_per_trace),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .sample              (sample),
        .qstat               (qstat),
        .push                (push),
        .push_entry          (push_entry)
    );

    dzte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    dzte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .qstat         (qstat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .stream_select (stream_select),
        .code_value    (code_value),
        .last_of_run   (last_of_run)
    );

endmodule
